[rtl/range_bearing_source_locator_assert.svh]
// Assertion macros shared by the source locator RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
// Reset is active low; checks are off while it is asserted.
`ifndef RANGE_BEARING_SOURCE_LOCATOR_ASSERT_SVH
`define RANGE_BEARING_SOURCE_LOCATOR_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent
`define RBSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbsl assertion failed (same cycle)");

// Consequence must hold in the cycle after the antecedent
`define RBSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbsl assertion failed (next cycle)");

`endif

[rtl/rbsl_pkg.sv]
// Shared types, widths, constants and the CORDIC arctangent table.
// No dependencies; used by every module of the source locator.
`timescale 1ns / 1ps
`default_nettype none

package rbsl_pkg;

	localparam int COORD_W  = 24;           // signed Q16.8 position
	localparam int RANGE_W  = 23;           // unsigned Q15.8 range
	localparam int ANGLE_W  = 16;           // binary angle
	localparam int THR_W    = 16;           // agreement threshold
	localparam int POS_W    = 4;            // position within a batch
	localparam int ROT_W    = 34;           // CORDIC datapath, Q.16 plus headroom
	localparam int MAG_W    = 31;           // prescaled start magnitude
	localparam int PROD_W   = RANGE_W + 16; // range times inverse gain
	localparam int RND_W    = ROT_W - 8;    // rotated value rounded to Q.8
	localparam int SUM_W    = RND_W + 1;    // rounded value plus vessel position

	localparam int BATCH_SIZE_DEF   = 10;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 32;

	localparam logic [15:0]      INV_GAIN  = 16'd39797; // 1/K as Q.16
	localparam logic [THR_W-1:0] THR_RESET = 16'd768;   // 3 m in Q16.8

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ROT_W-1:0]   rot_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// atan(2^-i) with the full circle at 2^32
	function automatic logic [31:0] atan_step(input int unsigned i);
		logic [31:0] a;
		case (i)
			0:       a = 32'd536870912;
			1:       a = 32'd316933406;
			2:       a = 32'd167458907;
			3:       a = 32'd85004756;
			4:       a = 32'd42667331;
			5:       a = 32'd21354465;
			6:       a = 32'd10679838;
			7:       a = 32'd5340245;
			8:       a = 32'd2670163;
			9:       a = 32'd1335087;
			10:      a = 32'd667544;
			11:      a = 32'd333772;
			12:      a = 32'd166886;
			13:      a = 32'd83443;
			14:      a = 32'd41721;
			15:      a = 32'd20860;
			16:      a = 32'd10430;
			17:      a = 32'd5215;
			18:      a = 32'd2607;
			19:      a = 32'd1303;
			20:      a = 32'd651;
			21:      a = 32'd325;
			22:      a = 32'd162;
			23:      a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

[rtl/rbsl_front.sv]
// Front end: sample intake, slot credit, and pipelined CORDIC rotation to a source point.
// Depends on rbsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsl_front #(
	parameter int CORDIC_STEPS = rbsl_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = rbsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [rbsl_pkg::RANGE_W-1:0]     range_dist,
	input  logic [rbsl_pkg::ANGLE_W-1:0]     bearing_angle,
	input  logic [rbsl_pkg::ANGLE_W-1:0]     heading_angle,
	input  rbsl_pkg::coord_t                 vessel_x,
	input  rbsl_pkg::coord_t                 vessel_y,
	input  logic                             release_slot,
	output logic                             point_valid,
	output rbsl_pkg::point_t                 point
);

	localparam int CRW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = rbsl_pkg::COORD_W;
	localparam int RW  = rbsl_pkg::ROT_W;
	localparam int SW  = rbsl_pkg::SUM_W;

	// Slot credit: items in the pipeline plus items in the queue
	logic [CRW-1:0] credit_q;
	logic           accept;

	assign full   = (credit_q == CRW'(QUEUE_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !release_slot) begin
			credit_q <= credit_q + 1'b1;
		end else if (!accept && release_slot) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	// Stage 1: angle difference, half-plane fold, prescale multiply
	logic [rbsl_pkg::ANGLE_W-1:0] theta, quad;
	logic [rbsl_pkg::PROD_W-1:0]  prod;

	assign theta = heading_angle - bearing_angle;
	assign quad  = theta + 16'd16384;
	assign prod  = rbsl_pkg::PROD_W'(range_dist) * rbsl_pkg::PROD_W'(rbsl_pkg::INV_GAIN);

	logic                         v_s1;
	logic                         neg_s1;
	logic [rbsl_pkg::ANGLE_W-1:0] ang_s1;
	logic [rbsl_pkg::MAG_W-1:0]   mag_s1;
	rbsl_pkg::coord_t             vx_s1, vy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= quad[rbsl_pkg::ANGLE_W-1];
		ang_s1 <= {theta[rbsl_pkg::ANGLE_W-1] ^ quad[rbsl_pkg::ANGLE_W-1],
			theta[rbsl_pkg::ANGLE_W-2:0]};
		mag_s1 <= prod[rbsl_pkg::PROD_W-1:8];
		vx_s1  <= vessel_x;
		vy_s1  <= vessel_y;
	end

	// Start vector and angle accumulator
	rbsl_pkg::rot_t mag_ext, init_x, init_z;

	assign mag_ext = RW'(mag_s1);
	assign init_x  = neg_s1 ? -mag_ext : mag_ext;
	assign init_z  = {{(RW - rbsl_pkg::ANGLE_W - 16){ang_s1[rbsl_pkg::ANGLE_W-1]}}, ang_s1, 16'd0};

	// CORDIC rotation stages, one micro-rotation per stage
	logic             rot_v_sn  [CORDIC_STEPS];
	rbsl_pkg::rot_t   rot_x_sn  [CORDIC_STEPS];
	rbsl_pkg::rot_t   rot_y_sn  [CORDIC_STEPS];
	rbsl_pkg::rot_t   rot_z_sn  [CORDIC_STEPS];
	rbsl_pkg::coord_t rot_vx_sn [CORDIC_STEPS];
	rbsl_pkg::coord_t rot_vy_sn [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic             vi;
		rbsl_pkg::rot_t   xi, yi, zi, xs, ys, at;
		rbsl_pkg::coord_t vxi, vyi;
		logic             dir;
		logic             v_sk;
		rbsl_pkg::rot_t   x_sk, y_sk, z_sk;
		rbsl_pkg::coord_t vx_sk, vy_sk;

		if (k == 0) begin : g_first
			assign vi  = v_s1;
			assign xi  = init_x;
			assign yi  = '0;
			assign zi  = init_z;
			assign vxi = vx_s1;
			assign vyi = vy_s1;
		end else begin : g_next
			assign vi  = rot_v_sn[k-1];
			assign xi  = rot_x_sn[k-1];
			assign yi  = rot_y_sn[k-1];
			assign zi  = rot_z_sn[k-1];
			assign vxi = rot_vx_sn[k-1];
			assign vyi = rot_vy_sn[k-1];
		end

		// floor shifts; a zero angle rotates positively
		assign xs  = xi >>> k;
		assign ys  = yi >>> k;
		assign at  = RW'(rbsl_pkg::atan_step(k));
		assign dir = !zi[RW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk <= 1'b0;
			end else begin
				v_sk <= vi;
			end
		end

		always_ff @(posedge clk) begin
			x_sk  <= dir ? (xi - ys) : (xi + ys);
			y_sk  <= dir ? (yi + xs) : (yi - xs);
			z_sk  <= dir ? (zi - at) : (zi + at);
			vx_sk <= vxi;
			vy_sk <= vyi;
		end

		assign rot_v_sn[k]  = v_sk;
		assign rot_x_sn[k]  = x_sk;
		assign rot_y_sn[k]  = y_sk;
		assign rot_z_sn[k]  = z_sk;
		assign rot_vx_sn[k] = vx_sk;
		assign rot_vy_sn[k] = vy_sk;
	end

	// Round to Q.8, add vessel position, saturate to 24 bits
	function automatic rbsl_pkg::coord_t sat_coord(input logic signed [SW-1:0] s);
		rbsl_pkg::coord_t r;
		if ((&s[SW-1:CW-1]) || !(|s[SW-1:CW-1])) begin
			r = s[CW-1:0];
		end else if (s[SW-1]) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = {1'b0, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

	rbsl_pkg::rot_t                      x_bias, y_bias;
	logic signed [rbsl_pkg::RND_W-1:0]   rx, ry;
	logic signed [SW-1:0]                sum_x, sum_y;

	assign x_bias = rot_x_sn[CORDIC_STEPS-1] + RW'(128);
	assign y_bias = rot_y_sn[CORDIC_STEPS-1] + RW'(128);
	assign rx     = x_bias[RW-1:8];
	assign ry     = y_bias[RW-1:8];
	assign sum_x  = SW'(rx) + SW'(rot_vx_sn[CORDIC_STEPS-1]);
	assign sum_y  = SW'(ry) + SW'(rot_vy_sn[CORDIC_STEPS-1]);

	assign point_valid = rot_v_sn[CORDIC_STEPS-1];
	assign point.x     = sat_coord(sum_x);
	assign point.y     = sat_coord(sum_y);

endmodule

`default_nettype wire

[rtl/rbsl_fifo.sv]
// Point queue between the CORDIC front end and the batch checker.
// Depends on rbsl_pkg for the point record.
`timescale 1ns / 1ps
`default_nettype none

module rbsl_fifo #(
	parameter int DEPTH = rbsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rbsl_pkg::point_t wdata,
	input  logic             rd,
	output logic             avail,
	output rbsl_pkg::point_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rbsl_pkg::point_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	// Storage write
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr && rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/rbsl_back.sv]
// Back end: batch counting, three-point agreement check, fix latch, result register,
// and the threshold register. Depends on rbsl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "range_bearing_source_locator_assert.svh"

module rbsl_back #(
	parameter int BATCH_SIZE = rbsl_pkg::BATCH_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_avail,
	input  rbsl_pkg::point_t               head,
	output logic                           take,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbsl_pkg::THR_W-1:0]     cfg_data,
	input  logic                           pop,
	output logic                           empty,
	output rbsl_pkg::coord_t               point_x,
	output rbsl_pkg::coord_t               point_y,
	output logic [rbsl_pkg::POS_W-1:0]     batch_position,
	output logic                           fix_now,
	output logic                           fix_held
);

	localparam int CW = rbsl_pkg::COORD_W;
	localparam int PW = rbsl_pkg::POS_W;

	// Threshold register, writable at any time
	logic [rbsl_pkg::THR_W-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rbsl_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Batch and fix state
	logic [PW-1:0]    count_q;
	rbsl_pkg::coord_t prev0_x_q, prev0_y_q, prev1_x_q, prev1_y_q;
	logic             fix_q;
	rbsl_pkg::coord_t fix_x_q, fix_y_q;

	// Result register
	logic             out_v_q;
	rbsl_pkg::coord_t out_x_q, out_y_q;
	logic [PW-1:0]    out_pos_q;
	logic             out_now_q, out_held_q;

	function automatic logic [CW:0] abs_diff(input rbsl_pkg::coord_t a, input rbsl_pkg::coord_t b);
		logic signed [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		return d[CW] ? -d : d;
	endfunction

	// Take the next point when the result register is free or being drained
	logic          fire;
	logic [PW:0]   next_cnt;
	logic          last;
	logic [CW:0]   thr_ext;
	logic          agree;

	assign fire     = head_avail && (!out_v_q || pop);
	assign take     = fire;
	assign next_cnt = {1'b0, count_q} + 1'b1;
	assign last     = (next_cnt >= (PW + 1)'(BATCH_SIZE));
	assign thr_ext  = (CW + 1)'(thr_q);
	assign agree    = (abs_diff(head.x, prev0_x_q) < thr_ext) &&
		(abs_diff(head.x, prev1_x_q) < thr_ext) &&
		(abs_diff(head.y, prev0_y_q) < thr_ext) &&
		(abs_diff(head.y, prev1_y_q) < thr_ext);

	// Control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			fix_q     <= 1'b0;
			prev0_x_q <= '0;
			prev0_y_q <= '0;
			prev1_x_q <= '0;
			prev1_y_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (fire && !fix_q) begin
				count_q   <= last ? '0 : next_cnt[PW-1:0];
				fix_q     <= last && agree;
				prev1_x_q <= prev0_x_q;
				prev1_y_q <= prev0_y_q;
				prev0_x_q <= head.x;
				prev0_y_q <= head.y;
			end
		end
	end

	// Fix point and result payload
	always_ff @(posedge clk) begin
		if (fire && !fix_q && last && agree) begin
			fix_x_q <= head.x;
			fix_y_q <= head.y;
		end
		if (fire) begin
			out_pos_q <= count_q;
			if (fix_q) begin
				out_x_q    <= fix_x_q;
				out_y_q    <= fix_y_q;
				out_now_q  <= 1'b0;
				out_held_q <= 1'b1;
			end else begin
				out_x_q    <= head.x;
				out_y_q    <= head.y;
				out_now_q  <= last && agree;
				out_held_q <= last && agree;
			end
		end
	end

	assign empty          = !out_v_q;
	assign point_x        = out_x_q;
	assign point_y        = out_y_q;
	assign batch_position = out_pos_q;
	assign fix_now        = out_now_q;
	assign fix_held       = out_held_q;

	// A fresh fix is always reported as held
	`RBSL_ASSERT_NOW(a_now_implies_held, clk, arst_n, out_v_q && out_now_q, out_held_q)
	// Once latched, the fix never clears
	`RBSL_ASSERT_NEXT(a_fix_sticky, clk, arst_n, fix_q, fix_q)
	// Batch counter stays inside the batch
	`RBSL_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, {1'b0, count_q} < (PW + 1)'(BATCH_SIZE))
	// While a fix is held the result carries the latched point
	`RBSL_ASSERT_NEXT(a_held_point, clk, arst_n, fire && fix_q,
		(out_x_q == fix_x_q) && (out_y_q == fix_y_q) && out_held_q && !out_now_q)

endmodule

`default_nettype wire

[rtl/range_bearing_source_locator.sv]
// A pushed sample passes stage 1, the CORDIC stages, the point queue and the result
// register before empty goes low. Throughput: one sample per cycle while full is low;
// the front end admits at most QUEUE_DEPTH samples that have not yet reached the result
// register, set by the point queue depth. Reset: asynchronous, active low; threshold
// returns to 768, batch count, history and fix flag clear, pipeline and queue empty.
`timescale 1ns / 1ps
`default_nettype none

module range_bearing_source_locator #(
	parameter int BATCH_SIZE   = rbsl_pkg::BATCH_SIZE_DEF,
	parameter int CORDIC_STEPS = rbsl_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = rbsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [rbsl_pkg::RANGE_W-1:0]   range_dist,
	input  logic [rbsl_pkg::ANGLE_W-1:0]   bearing_angle,
	input  logic [rbsl_pkg::ANGLE_W-1:0]   heading_angle,
	input  rbsl_pkg::coord_t               vessel_x,
	input  rbsl_pkg::coord_t               vessel_y,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbsl_pkg::THR_W-1:0]     cfg_data,
	input  logic                           pop,
	output logic                           empty,
	output rbsl_pkg::coord_t               point_x,
	output rbsl_pkg::coord_t               point_y,
	output logic [rbsl_pkg::POS_W-1:0]     batch_position,
	output logic                           fix_now,
	output logic                           fix_held
);

	logic             pt_valid;
	rbsl_pkg::point_t pt;
	logic             q_avail;
	rbsl_pkg::point_t q_head;
	logic             q_take;

	// Intake and rotation
	rbsl_front #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.QUEUE_DEPTH  (QUEUE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.range_dist    (range_dist),
		.bearing_angle (bearing_angle),
		.heading_angle (heading_angle),
		.vessel_x      (vessel_x),
		.vessel_y      (vessel_y),
		.release_slot  (q_take),
		.point_valid   (pt_valid),
		.point         (pt)
	);

	// Decoupling queue
	rbsl_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (pt_valid),
		.wdata  (pt),
		.rd     (q_take),
		.avail  (q_avail),
		.rdata  (q_head)
	);

	// Batch check and result
	rbsl_back #(
		.BATCH_SIZE (BATCH_SIZE)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_avail     (q_avail),
		.head           (q_head),
		.take           (q_take),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.pop            (pop),
		.empty          (empty),
		.point_x        (point_x),
		.point_y        (point_y),
		.batch_position (batch_position),
		.fix_now        (fix_now),
		.fix_held       (fix_held)
	);

endmodule

`default_nettype wire
